[rtl/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, register indexes, reset values and gesture codes for the
// button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  // Field and bus widths
  localparam int TICK_W = 32;
  localparam int CFG_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int IDX_W  = 2;

  // Gesture codes
  localparam logic [1:0] GEST_NONE   = 2'd0;
  localparam logic [1:0] GEST_CLICK  = 2'd1;
  localparam logic [1:0] GEST_DOUBLE = 2'd2;
  localparam logic [1:0] GEST_LONG   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_PAIR_WINDOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAP_LIMIT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_SINGLE_LIMIT = 2'd2;
  localparam logic [IDX_W-1:0] REG_LONG_IDLE    = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_PAIR_WINDOW  = 16'd100;
  localparam logic [CFG_W-1:0] RST_GAP_LIMIT    = 16'd30;
  localparam logic [CFG_W-1:0] RST_SINGLE_LIMIT = 16'd32;
  localparam logic [CFG_W-1:0] RST_LONG_IDLE    = 16'd100;

  // Timing thresholds handed from the register file to the core
  typedef struct packed {
    logic [CFG_W-1:0] pair_window;
    logic [CFG_W-1:0] gap_limit;
    logic [CFG_W-1:0] single_limit;
    logic [CFG_W-1:0] long_idle;
  } bgc_cfg_t;

endpackage

[rtl/button_gesture_classifier.sv]
// Path: a sample passes the input register, then the result register, where
// its result is held until the result transaction completes.
// Throughput: one sample per cycle unless out_ready stalls the result; the
// stamp and gesture state update as each sample moves on, with no gap.
// Reset: synchronous, active high; clears state, pipeline valids and loads
// the threshold register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies click, double click and long press from timestamped pin samples.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bgc_pkg::DATA_W-1:0]  pwdata,
  output logic [bgc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        pin_level,
  input  logic [bgc_pkg::TICK_W-1:0]  now_ticks,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  gesture,
  output logic                        pending
);
  import bgc_pkg::*;

  bgc_cfg_t cfg;

  // Threshold registers
  bgc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sample pipeline and gesture rules
  bgc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pin_level (pin_level),
    .now_ticks (now_ticks),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gesture   (gesture),
    .pending   (pending)
  );

endmodule

[rtl/bgc_regs.sv]
// ----------------------------------------------------------------------------
// bgc_regs
// APB-style register file holding the four 16-bit timing thresholds.
// ----------------------------------------------------------------------------
module bgc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bgc_pkg::DATA_W-1:0]  pwdata,
  output logic [bgc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bgc_pkg::bgc_cfg_t           cfg
);
  import bgc_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] idx;
  logic [CFG_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];

  // Write a register at the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pair_window  <= RST_PAIR_WINDOW;
      cfg.gap_limit    <= RST_GAP_LIMIT;
      cfg.single_limit <= RST_SINGLE_LIMIT;
      cfg.long_idle    <= RST_LONG_IDLE;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAIR_WINDOW:  cfg.pair_window  <= pwdata[CFG_W-1:0];
        REG_GAP_LIMIT:    cfg.gap_limit    <= pwdata[CFG_W-1:0];
        REG_SINGLE_LIMIT: cfg.single_limit <= pwdata[CFG_W-1:0];
        REG_LONG_IDLE:    cfg.long_idle    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Select read data
  always_comb begin
    unique case (idx)
      REG_PAIR_WINDOW:  rd_val = cfg.pair_window;
      REG_GAP_LIMIT:    rd_val = cfg.gap_limit;
      REG_SINGLE_LIMIT: rd_val = cfg.single_limit;
      REG_LONG_IDLE:    rd_val = cfg.long_idle;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-CFG_W){1'b0}}, rd_val};

endmodule

[rtl/bgc_core.sv]
// ----------------------------------------------------------------------------
// bgc_core
// Input register, edge/stamp state, gesture rules and result register.
// One sample is evaluated per cycle, unless the result register stalls, against the state left by the last one.
// ----------------------------------------------------------------------------
module bgc_core (
  input  logic                        clk,
  input  logic                        rst,
  input  bgc_pkg::bgc_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        pin_level,
  input  logic [bgc_pkg::TICK_W-1:0]  now_ticks,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  gesture,
  output logic                        pending
);
  import bgc_pkg::*;

  // Input stage
  logic              s1_valid;
  logic              s1_level;
  logic [TICK_W-1:0] s1_ticks;
  logic              advance;

  // Architectural state
  logic              last_level;
  logic [TICK_W-1:0] rise_stamp;
  logic [TICK_W-1:0] fall_stamp;
  logic [TICK_W-1:0] prior_fall_stamp;
  logic              armed;
  logic [1:0]        gesture_reg;

  // Next values
  logic [TICK_W-1:0] rise_next;
  logic [TICK_W-1:0] fall_next;
  logic [TICK_W-1:0] prior_fall_next;
  logic              armed_next;
  logic [1:0]        gesture_next;

  // Rule terms
  logic [TICK_W-1:0] pair_w, gap_w, single_w, long_w;
  logic [TICK_W-1:0] since_fall, since_rise, rise_gap, fall_gap, prior_gap;
  logic              fall_after_rise, rise_after_fall;
  logic              arm_hit, click_hit, double_hit, long_hit;
  logic              armed_a, armed_c;

  assign advance  = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | advance;

  // Capture the sample transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level <= pin_level;
      s1_ticks <= now_ticks;
    end
  end

  // Edge detection and stamp update
  always_comb begin
    rise_next       = rise_stamp;
    fall_next       = fall_stamp;
    prior_fall_next = prior_fall_stamp;
    if (!last_level && s1_level) begin
      rise_next = s1_ticks;
    end
    if (last_level && !s1_level) begin
      prior_fall_next = fall_stamp;
      fall_next       = s1_ticks;
    end
  end

  assign pair_w   = {{(TICK_W-CFG_W){1'b0}}, cfg.pair_window};
  assign gap_w    = {{(TICK_W-CFG_W){1'b0}}, cfg.gap_limit};
  assign single_w = {{(TICK_W-CFG_W){1'b0}}, cfg.single_limit};
  assign long_w   = {{(TICK_W-CFG_W){1'b0}}, cfg.long_idle};

  // Wrapping differences and raw stamp order
  assign since_fall      = s1_ticks - fall_next;
  assign since_rise      = s1_ticks - rise_next;
  assign fall_gap        = fall_next - rise_next;
  assign rise_gap        = rise_next - fall_next;
  assign prior_gap       = rise_next - prior_fall_next;
  assign fall_after_rise = fall_next > rise_next;
  assign rise_after_fall = rise_next > fall_next;

  // Rules in order, each on what the earlier ones left
  assign arm_hit    = fall_after_rise && (fall_gap <= pair_w);
  assign armed_a    = armed | arm_hit;
  assign click_hit  = armed_a && (since_fall > gap_w) && fall_after_rise &&
                      (prior_gap > gap_w) && (since_fall < single_w);
  assign armed_c    = armed_a & ~click_hit;
  assign double_hit = armed_c && (since_fall < gap_w) && rise_after_fall;
  assign long_hit   = (since_rise > long_w) && rise_after_fall && (rise_gap > gap_w);
  assign armed_next = armed_c & ~double_hit & ~long_hit;

  // Latest matching rule wins
  always_comb begin
    priority if (long_hit) begin
      gesture_next = GEST_LONG;
    end else if (double_hit) begin
      gesture_next = GEST_DOUBLE;
    end else if (click_hit) begin
      gesture_next = GEST_CLICK;
    end else begin
      gesture_next = gesture_reg;
    end
  end

  // Commit state when the sample moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level       <= 1'b0;
      rise_stamp       <= '0;
      fall_stamp       <= '0;
      prior_fall_stamp <= '0;
      armed            <= 1'b0;
      gesture_reg      <= GEST_NONE;
    end else if (advance) begin
      last_level       <= s1_level;
      rise_stamp       <= rise_next;
      fall_stamp       <= fall_next;
      prior_fall_stamp <= prior_fall_next;
      armed            <= armed_next;
      gesture_reg      <= gesture_next;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture <= gesture_next;
      pending <= armed_next;
    end
  end

endmodule

[rtl/bgc_checker.sv]
// ----------------------------------------------------------------------------
// bgc_checker
// Port-level checks for the button gesture classifier, bound to the top.
// ----------------------------------------------------------------------------
module bgc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       pready,
  input  logic       in_ready,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] gesture,
  input  logic       pending
);
  import bgc_pkg::*;

  logic seen_gesture;

  // Track whether any result transaction has carried a gesture
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_gesture <= 1'b0;
    end else if (out_valid && out_ready && gesture != GEST_NONE) begin
      seen_gesture <= 1'b1;
    end
  end

  // Gesture is sticky: once reported it never returns to none
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen_gesture) |-> gesture != GEST_NONE)
    else $error("gesture returned to none");

  // Result register empties on reset
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A free result register never stalls the input side
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Config port never inserts wait states
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(gesture) && $stable(pending)))
    else $error("stalled result changed");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .gesture   (gesture),
  .pending   (pending)
);
